### rtl/axis_vector_rotation_assert.svh
// assertion macros for the checker file of the vector rotation block
// no dependencies; take in with an include of the bare file name
`ifndef AXIS_VECTOR_ROTATION_ASSERT_SVH
`define AXIS_VECTOR_ROTATION_ASSERT_SVH

// same-cycle implication, off while reset is low
`define AVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vector rotation check failed");

// next-cycle implication, off while reset is low
`define AVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vector rotation check failed");

// next-cycle implication, checked during reset as well
`define AVR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vector rotation check failed");

`endif

### rtl/avr_pkg.sv
// types, constants and the arctangent table of the vector rotation block
// no dependencies; used by all other files but the assertion header
`default_nettype none

package avr_pkg;

  // default and cap for the number of cordic iterations
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int MAX_STEPS        = 32;

  // field widths
  localparam int OP_W    = 2;
  localparam int ANGLE_W = 20;
  localparam int COORD_W = 32;

  // internal widths: angle after scaling, after wrap, cordic x/y and z
  localparam int ANG_W  = 35;
  localparam int WRAP_W = 33;
  localparam int XW     = 33;
  localparam int ZW     = 33;

  // angle constants in q.30 radians and the cordic gain in q.30
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint CORDIC_GAIN = 64'sd652032874;

  typedef logic [OP_W-1:0]           avr_op_t;
  typedef logic signed [ANGLE_W-1:0] avr_angle_t;
  typedef logic signed [COORD_W-1:0] avr_coord_t;

  // axis codes
  localparam avr_op_t OP_X    = 2'd0;
  localparam avr_op_t OP_Y    = 2'd1;
  localparam avr_op_t OP_Z    = 2'd2;
  localparam avr_op_t OP_NONE = 2'd3;

  // one stage of the cordic chain with the vector riding along
  typedef struct packed {
    logic                 valid;
    avr_op_t              op;
    avr_coord_t           vx;
    avr_coord_t           vy;
    avr_coord_t           vz;
    logic                 neg;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [ZW-1:0] cz;
  } avr_stage_t;

  // atan(2^-i) in q.30
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:       v = 30'h3243F6A8;
      1:       v = 30'h1DAC6705;
      2:       v = 30'h0FADBAFC;
      3:       v = 30'h07F56EA6;
      4:       v = 30'h03FEAB76;
      5:       v = 30'h01FFD55B;
      6:       v = 30'h00FFFAAA;
      7:       v = 30'h007FFF55;
      8:       v = 30'h003FFFEA;
      9:       v = 30'h001FFFFD;
      10:      v = 30'h000FFFFF;
      11:      v = 30'h0007FFFF;
      12:      v = 30'h0003FFFF;
      13:      v = 30'h0001FFFF;
      14:      v = 30'h0000FFFF;
      15:      v = 30'h00007FFF;
      16:      v = 30'h00003FFF;
      17:      v = 30'h00001FFF;
      18:      v = 30'h00000FFF;
      19:      v = 30'h000007FF;
      20:      v = 30'h000003FF;
      21:      v = 30'h000001FF;
      22:      v = 30'h000000FF;
      23:      v = 30'h0000007F;
      24:      v = 30'h0000003F;
      25:      v = 30'h0000001F;
      26:      v = 30'h0000000F;
      27:      v = 30'h00000008;
      28:      v = 30'h00000004;
      29:      v = 30'h00000002;
      30:      v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/avr_in_if.sv
// input channel of the vector rotation block: valid/ready with axis, angle, vector
// depends on avr_pkg
`default_nettype none

interface avr_in_if;
  logic                valid;
  logic                ready;
  avr_pkg::avr_op_t    operation;
  avr_pkg::avr_angle_t angle;
  avr_pkg::avr_coord_t vec_x;
  avr_pkg::avr_coord_t vec_y;
  avr_pkg::avr_coord_t vec_z;

  modport source (output valid, output operation, output angle, output vec_x,
                  output vec_y, output vec_z, input ready);
  modport sink   (input valid, input operation, input angle, input vec_x,
                  input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

### rtl/avr_out_if.sv
// result channel of the vector rotation block: valid/ready with vector and flag
// depends on avr_pkg
`default_nettype none

interface avr_out_if;
  logic                valid;
  logic                ready;
  avr_pkg::avr_coord_t out_x;
  avr_pkg::avr_coord_t out_y;
  avr_pkg::avr_coord_t out_z;
  logic                saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input saturated, output ready);
endinterface

`default_nettype wire

### rtl/avr_cordic_cell.sv
// one rotation-mode cordic iteration with its stage register
// depends on avr_pkg
`default_nettype none

module avr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  avr_pkg::avr_stage_t stage_i,
  output avr_pkg::avr_stage_t stage_o
);
  import avr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_q30(IDX)));

  logic signed [XW-1:0] sh_x;
  logic signed [XW-1:0] sh_y;
  avr_stage_t           stage_nxt;
  avr_stage_t           stage_r;

  // floor shifts of the incoming pair
  assign sh_x = stage_i.cx >>> IDX;
  assign sh_y = stage_i.cy >>> IDX;

  // micro-rotation toward zero residual angle
  always_comb begin
    stage_nxt = stage_i;
    if (!stage_i.cz[ZW-1]) begin
      stage_nxt.cx = stage_i.cx - sh_y;
      stage_nxt.cy = stage_i.cy + sh_x;
      stage_nxt.cz = stage_i.cz - ATAN;
    end else begin
      stage_nxt.cx = stage_i.cx + sh_y;
      stage_nxt.cy = stage_i.cy - sh_x;
      stage_nxt.cz = stage_i.cz + ATAN;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

### rtl/avr_angle_reduce.sv
// two-stage angle reduction into [-pi/2, pi/2] and cordic seed
// depends on avr_pkg
`default_nettype none

module avr_angle_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  avr_pkg::avr_op_t    op,
  input  avr_pkg::avr_angle_t angle,
  input  avr_pkg::avr_coord_t vx,
  input  avr_pkg::avr_coord_t vy,
  input  avr_pkg::avr_coord_t vz,
  output avr_pkg::avr_stage_t stage_o
);
  import avr_pkg::*;

  localparam logic signed [ANG_W-1:0]  PI_A      = ANG_W'(Q30_PI);
  localparam logic signed [ANG_W-1:0]  TWO_PI_A  = ANG_W'(Q30_TWO_PI);
  localparam logic signed [WRAP_W-1:0] PI_W      = WRAP_W'(Q30_PI);
  localparam logic signed [WRAP_W-1:0] HALF_PI_W = WRAP_W'(Q30_HALF_PI);
  localparam logic signed [XW-1:0]     GAIN_X    = XW'(CORDIC_GAIN);

  logic signed [ANG_W-1:0]  ang_ext;
  logic signed [ANG_W-1:0]  ang_wrap;
  logic                     w_valid_r;
  avr_op_t                  w_op_r;
  avr_coord_t               w_vx_r;
  avr_coord_t               w_vy_r;
  avr_coord_t               w_vz_r;
  logic signed [WRAP_W-1:0] w_ang_r;
  logic signed [WRAP_W-1:0] fold;
  logic                     fold_neg;
  avr_stage_t               seed_nxt;
  avr_stage_t               seed_r;

  // scale q3.16 to q.30 and wrap once into (-pi, pi]
  assign ang_ext = ANG_W'(angle) <<< 14;

  always_comb begin
    if (ang_ext > PI_A) begin
      ang_wrap = ang_ext - TWO_PI_A;
    end else if (ang_ext <= -PI_A) begin
      ang_wrap = ang_ext + TWO_PI_A;
    end else begin
      ang_wrap = ang_ext;
    end
  end

  // wrap stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
    end else if (en) begin
      w_valid_r <= in_valid;
      w_op_r    <= op;
      w_vx_r    <= vx;
      w_vy_r    <= vy;
      w_vz_r    <= vz;
      w_ang_r   <= ang_wrap[WRAP_W-1:0];
    end
  end

  // fold outer half-turns in, remember to negate cos and sin
  always_comb begin
    fold     = w_ang_r;
    fold_neg = 1'b0;
    if (w_ang_r > HALF_PI_W) begin
      fold     = w_ang_r - PI_W;
      fold_neg = 1'b1;
    end else if (w_ang_r < -HALF_PI_W) begin
      fold     = w_ang_r + PI_W;
      fold_neg = 1'b1;
    end
  end

  // cordic seed
  always_comb begin
    seed_nxt.valid = w_valid_r;
    seed_nxt.op    = w_op_r;
    seed_nxt.vx    = w_vx_r;
    seed_nxt.vy    = w_vy_r;
    seed_nxt.vz    = w_vz_r;
    seed_nxt.neg   = fold_neg;
    seed_nxt.cx    = GAIN_X;
    seed_nxt.cy    = '0;
    seed_nxt.cz    = ZW'(fold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r.valid <= 1'b0;
    end else if (en) begin
      seed_r <= seed_nxt;
    end
  end

  assign stage_o = seed_r;

endmodule

`default_nettype wire

### rtl/avr_rotate.sv
// applies cos/sin to the selected coordinate pair: product stage, then
// round, clamp and output register; depends on avr_pkg
`default_nettype none

module avr_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  avr_pkg::avr_stage_t stage_i,
  output logic                out_valid,
  output avr_pkg::avr_coord_t out_x,
  output avr_pkg::avr_coord_t out_y,
  output avr_pkg::avr_coord_t out_z,
  output logic                out_sat
);
  import avr_pkg::*;

  localparam int PROD_W = XW + COORD_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - 30;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd536870912);
  localparam logic signed [RND_W-1:0] MAX_R    = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] MIN_R    = RND_W'(-64'sd2147483648);

  logic signed [XW-1:0]     cos_v;
  logic signed [XW-1:0]     sin_v;
  avr_coord_t               pa;
  avr_coord_t               pb;
  logic                     m_valid_r;
  avr_op_t                  m_op_r;
  avr_coord_t               m_vx_r;
  avr_coord_t               m_vy_r;
  avr_coord_t               m_vz_r;
  logic signed [PROD_W-1:0] pca_r;
  logic signed [PROD_W-1:0] psb_r;
  logic signed [PROD_W-1:0] psa_r;
  logic signed [PROD_W-1:0] pcb_r;
  logic signed [ACC_W-1:0]  acc_a;
  logic signed [ACC_W-1:0]  acc_b;
  logic [COORD_W:0]         rs_a;
  logic [COORD_W:0]         rs_b;
  avr_coord_t               ox_nxt;
  avr_coord_t               oy_nxt;
  avr_coord_t               oz_nxt;
  logic                     sat_nxt;
  logic                     out_valid_r;
  avr_coord_t               out_x_r;
  avr_coord_t               out_y_r;
  avr_coord_t               out_z_r;
  logic                     out_sat_r;

  // round half up to q16.16 and clamp; msb is the clamp flag
  function automatic logic [COORD_W:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [RND_W-1:0] r;
    logic [COORD_W:0]        res;
    sum = acc + HALF_LSB;
    r   = RND_W'(sum >>> 30);
    if (r > MAX_R) begin
      res = {1'b1, MAX_R[COORD_W-1:0]};
    end else if (r < MIN_R) begin
      res = {1'b1, MIN_R[COORD_W-1:0]};
    end else begin
      res = {1'b0, r[COORD_W-1:0]};
    end
    return res;
  endfunction

  // signed cos and sin, pair selection per axis
  assign cos_v = stage_i.neg ? -stage_i.cx : stage_i.cx;
  assign sin_v = stage_i.neg ? -stage_i.cy : stage_i.cy;

  always_comb begin
    case (stage_i.op)
      OP_X: begin
        pa = stage_i.vy;
        pb = stage_i.vz;
      end
      OP_Y: begin
        pa = stage_i.vz;
        pb = stage_i.vx;
      end
      default: begin
        pa = stage_i.vx;
        pb = stage_i.vy;
      end
    endcase
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= stage_i.valid;
      m_op_r    <= stage_i.op;
      m_vx_r    <= stage_i.vx;
      m_vy_r    <= stage_i.vy;
      m_vz_r    <= stage_i.vz;
      pca_r     <= cos_v * pa;
      psb_r     <= sin_v * pb;
      psa_r     <= sin_v * pa;
      pcb_r     <= cos_v * pb;
    end
  end

  // a' = c*a - s*b, b' = s*a + c*b
  assign acc_a = ACC_W'(pca_r) - ACC_W'(psb_r);
  assign acc_b = ACC_W'(psa_r) + ACC_W'(pcb_r);
  assign rs_a  = rnd_sat(acc_a);
  assign rs_b  = rnd_sat(acc_b);

  // route rotated pair back, axis coordinate passes through; OP_NONE passes all, flag low
  always_comb begin
    ox_nxt  = m_vx_r;
    oy_nxt  = m_vy_r;
    oz_nxt  = m_vz_r;
    sat_nxt = rs_a[COORD_W] | rs_b[COORD_W];
    case (m_op_r)
      OP_X: begin
        oy_nxt = rs_a[COORD_W-1:0];
        oz_nxt = rs_b[COORD_W-1:0];
      end
      OP_Y: begin
        oz_nxt = rs_a[COORD_W-1:0];
        ox_nxt = rs_b[COORD_W-1:0];
      end
      OP_Z: begin
        ox_nxt = rs_a[COORD_W-1:0];
        oy_nxt = rs_b[COORD_W-1:0];
      end
      default: begin
        sat_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
      out_x_r     <= ox_nxt;
      out_y_r     <= oy_nxt;
      out_z_r     <= oz_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_sat   = out_sat_r;

endmodule

`default_nettype wire

### rtl/axis_vector_rotation.sv
// top level of the principal-axis vector rotation block
// depends on avr_pkg, avr_in_if, avr_out_if, avr_angle_reduce, avr_cordic_cell,
// avr_rotate
//
//   channel   dir   transfer contents
//   in_ch     in    operation, angle, vec_x, vec_y, vec_z
//   out_ch    out   out_x, out_y, out_z, saturated
//
// one transfer in and one out per cycle when the output is taken
// stages in order (capped at 32 cordic cells): two angle
// reduction stages, one cell per cordic iteration, a product stage and the
// output register
// a stalled output freezes the whole chain; in_ch.ready is low only while a
// result waits and out_ch.ready is low
// synchronous reset clears the valid bit of every stage
`default_nettype none

module axis_vector_rotation #(
  parameter int CORDIC_STEPS = avr_pkg::CORDIC_STEPS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  avr_in_if.sink  in_ch,
  avr_out_if.source out_ch
);
  import avr_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic       en;
  logic       res_valid;
  avr_stage_t chain [0:NSTEPS];

  // chain advances whenever the output slot is free or being taken
  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  avr_angle_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .op       (in_ch.operation),
    .angle    (in_ch.angle),
    .vx       (in_ch.vec_x),
    .vy       (in_ch.vec_y),
    .vz       (in_ch.vec_z),
    .stage_o  (chain[0])
  );

  // cordic chain, one cell per iteration
  for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
    avr_cordic_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  avr_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .stage_i   (chain[NSTEPS]),
    .out_valid (res_valid),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z),
    .out_sat   (out_ch.saturated)
  );

  assign out_ch.valid = res_valid;

endmodule

`default_nettype wire

### rtl/avr_checker.sv
// port-level checks of the vector rotation block and their bind
// depends on avr_pkg, axis_vector_rotation_assert.svh, axis_vector_rotation
`default_nettype none

`include "axis_vector_rotation_assert.svh"

module avr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input avr_pkg::avr_coord_t out_x,
  input avr_pkg::avr_coord_t out_y,
  input avr_pkg::avr_coord_t out_z,
  input logic                saturated
);
  import avr_pkg::*;

  localparam avr_coord_t CMAX = 32'sh7FFFFFFF;
  localparam avr_coord_t CMIN = 32'sh80000000;

  logic               x_edge;
  logic               y_edge;
  logic               z_edge;
  logic [3*COORD_W:0] payload;

  assign x_edge  = (out_x == CMAX) || (out_x == CMIN);
  assign y_edge  = (out_y == CMAX) || (out_y == CMIN);
  assign z_edge  = (out_z == CMAX) || (out_z == CMIN);
  assign payload = {out_x, out_y, out_z, saturated};

  // a stalled result stays offered
  `AVR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `AVR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(payload))

  // reset empties the output
  `AVR_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // input is never blocked while the output slot is empty
  `AVR_ASSERT_SAME(a_ready_free, clk, rst_n, !out_valid, in_ready)

  // a clamp flag goes with at least one coordinate at a range limit
  `AVR_ASSERT_SAME(a_sat_limit, clk, rst_n, out_valid && saturated, x_edge || y_edge || z_edge)

endmodule

bind axis_vector_rotation avr_checker u_avr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .saturated (out_ch.saturated)
);

`default_nettype wire
